// ----- rtl/sem_pkg.sv -----
package sem_pkg;

    // Frame geometry
    localparam int MAX_WIDTH   = 2048;
    localparam int CFG_W       = 12;
    localparam int ROW_W       = 12;
    localparam int MIN_DIM     = 3;
    localparam int PIXEL_W     = 8;

    // Gradient and result widths
    localparam int GRAD_W      = 11;
    localparam int SUM_W       = 10;
    localparam int MAG_W       = 11;

    // Queue between window stage and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register map
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_W   = 1;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0]     IMAGE_HEIGHT_RST = 12'd480;

    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
    } sem_cfg_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_v;
        logic signed [GRAD_W-1:0] grad_h;
        logic                     last;
    } sem_grad_t;

endpackage

// ----- rtl/sem_pixel_if.sv -----
interface sem_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [sem_pkg::PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ----- rtl/sem_result_if.sv -----
interface sem_result_if;
    logic                      valid;
    logic                      ready;
    logic [sem_pkg::MAG_W-1:0] magnitude;
    logic                      last;

    modport source (output valid, output magnitude, output last, input ready);
    modport sink   (input valid, input magnitude, input last, output ready);
endinterface

// ----- rtl/sobel_edge_magnitude.sv -----
// Sobel edge magnitude over a raster-order 8-bit pixel stream. One pixel word is taken
// per clock for as long as the result side keeps up; the 3x3 window, both line stores and
// the gradient adders all run at one word per cycle. A result (|Gv| + |Gh|, 0 to 1530)
// belongs to each interior pixel and passes through the result queue and output register
// after the pixel below and right of it is taken; border pixels give none, and the final
// interior result of a frame carries last. pixel_stream.ready falls only when the
// four-word result queue, counting the two words still in the window pipeline, is full.
// The line stores are two single-port-read, single-port-write RAMs of MAX_WIDTH bytes,
// not cleared after reset. image_width (0x0) and image_height (0x4) are 12-bit registers,
// clamped to 3..MAX_WIDTH and 3..4095. Write them only while the block is idle; unchecked.
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    sem_pixel_if.sink                        pixel_stream,
    sem_result_if.source                     result_stream,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sem_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sem_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sem_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [sem_pkg::CFG_W-1:0]    image_width_reg, image_width_next;
    logic [sem_pkg::CFG_W-1:0]    image_height_reg, image_height_next;
    logic [sem_pkg::REG_IDX_W-1:0] reg_idx;
    logic                         cfg_write;
    sem_pkg::sem_cfg_t            cfg;

    logic                         push_valid;
    sem_pkg::sem_grad_t           push_word;
    logic                         pop_valid;
    logic                         pop;
    sem_pkg::sem_grad_t           pop_word;
    logic [sem_pkg::QCOUNT_W-1:0] queue_count;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register write decode
    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                sem_pkg::REG_IMAGE_WIDTH:  image_width_next  = pwdata[sem_pkg::CFG_W-1:0];
                sem_pkg::REG_IMAGE_HEIGHT: image_height_next = pwdata[sem_pkg::CFG_W-1:0];
                default:                   image_width_next  = image_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= sem_pkg::IMAGE_WIDTH_RST;
            image_height_reg <= sem_pkg::IMAGE_HEIGHT_RST;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    // Register read mux
    always_comb
    begin
        unique case (reg_idx)
            sem_pkg::REG_IMAGE_WIDTH:  prdata = sem_pkg::APB_DATA_W'(image_width_reg);
            sem_pkg::REG_IMAGE_HEIGHT: prdata = sem_pkg::APB_DATA_W'(image_height_reg);
            default:                   prdata = '0;
        endcase
    end

    assign cfg.image_width  = image_width_reg;
    assign cfg.image_height = image_height_reg;

    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (pixel_stream.valid),
        .in_ready    (pixel_stream.ready),
        .pixel       (pixel_stream.pixel),
        .queue_count (queue_count),
        .push_valid  (push_valid),
        .push_word   (push_word)
    );

    sem_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_word   (pop_word),
        .count      (queue_count)
    );

    sem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_word  (pop_word),
        .out_valid (result_stream.valid),
        .out_ready (result_stream.ready),
        .magnitude (result_stream.magnitude),
        .last      (result_stream.last)
    );

endmodule

// ----- rtl/sem_front.sv -----
module sem_front #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sem_pkg::sem_cfg_t            cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [sem_pkg::PIXEL_W-1:0]  pixel,
    input  logic [sem_pkg::QCOUNT_W-1:0] queue_count,
    output logic                         push_valid,
    output sem_pkg::sem_grad_t           push_word
);

    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W = (COL_W + 1 > sem_pkg::CFG_W + 1) ? COL_W + 1 : sem_pkg::CFG_W + 1;
    localparam int CRD_W = sem_pkg::QCOUNT_W + 1;
    localparam int PW    = sem_pkg::PIXEL_W;

    // Position counters
    logic [COL_W-1:0]        col_reg, col_next;
    logic [sem_pkg::ROW_W-1:0] row_reg, row_next;

    // Accept stage outputs
    logic                    s1_valid_reg;
    logic                    s1_produce_reg;
    logic                    s1_last_reg;
    logic [PW-1:0]           s1_pixel_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic [PW-1:0]           top_rd_reg;
    logic [PW-1:0]           mid_rd_reg;

    // Line stores: two previous rows
    logic [PW-1:0]           top_line_mem [MAX_WIDTH];
    logic [PW-1:0]           mid_line_mem [MAX_WIDTH];

    // Left and centre window columns: top, middle, bottom
    logic [PW-1:0]           win_reg [6];

    // Gradient stage
    logic                    s2_valid_reg;
    sem_pkg::sem_grad_t      s2_word_reg;
    sem_pkg::sem_grad_t      s2_word_next;

    logic                    accept;
    logic [CMP_W-1:0]        width_eff;
    logic [CMP_W-1:0]        last_col;
    logic [sem_pkg::ROW_W-1:0] height_eff;
    logic [sem_pkg::ROW_W-1:0] last_row;
    logic                    row_end;
    logic                    frame_end;
    logic [CRD_W-1:0]        credits_used;

    logic [PW-1:0]           top_px, mid_px, bot_px;
    logic [sem_pkg::SUM_W-1:0] sum_top, sum_bot, sum_left, sum_right;

    // Reserve a queue slot for every word in flight
    assign credits_used = CRD_W'(queue_count) + CRD_W'(s1_valid_reg) + CRD_W'(s2_valid_reg);
    assign in_ready     = credits_used < CRD_W'(sem_pkg::QUEUE_DEPTH);
    assign accept       = in_valid && in_ready;

    // Clamp frame geometry
    always_comb
    begin
        width_eff = CMP_W'(cfg.image_width);
        if (width_eff < CMP_W'(sem_pkg::MIN_DIM))
        begin
            width_eff = CMP_W'(sem_pkg::MIN_DIM);
        end
        if (width_eff > CMP_W'(MAX_WIDTH))
        begin
            width_eff = CMP_W'(MAX_WIDTH);
        end
        last_col = width_eff - CMP_W'(1);

        height_eff = cfg.image_height;
        if (height_eff < sem_pkg::ROW_W'(sem_pkg::MIN_DIM))
        begin
            height_eff = sem_pkg::ROW_W'(sem_pkg::MIN_DIM);
        end
        last_row = height_eff - sem_pkg::ROW_W'(1);
    end

    assign row_end   = CMP_W'(col_reg) >= last_col;
    assign frame_end = row_end && (row_reg >= last_row);

    // Advance column and row, wrap at row and frame end
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + sem_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s1_produce_reg <= 1'b0;
            s1_last_reg    <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            s1_valid_reg   <= accept;
            s1_produce_reg <= (col_reg >= COL_W'(2)) && (row_reg >= sem_pkg::ROW_W'(2));
            s1_last_reg    <= frame_end;
            s2_valid_reg   <= s1_valid_reg && s1_produce_reg;
        end
    end

    // Read both line stores on accept, write them back in the following cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_rd_reg   <= top_line_mem[col_reg];
            mid_rd_reg   <= mid_line_mem[col_reg];
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_reg;
        end
        if (s1_valid_reg)
        begin
            top_line_mem[s1_col_reg] <= mid_rd_reg;
            mid_line_mem[s1_col_reg] <= s1_pixel_reg;
        end
    end

    assign top_px = top_rd_reg;
    assign mid_px = mid_rd_reg;
    assign bot_px = s1_pixel_reg;

    // Shift the window by one column per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_px;
            win_reg[4] <= mid_px;
            win_reg[5] <= bot_px;
        end
    end

    // Weighted 1,2,1 sums for the four window edges
    assign sum_top   = sem_pkg::SUM_W'(win_reg[0]) + {1'b0, win_reg[3], 1'b0}
                     + sem_pkg::SUM_W'(top_px);
    assign sum_bot   = sem_pkg::SUM_W'(win_reg[2]) + {1'b0, win_reg[5], 1'b0}
                     + sem_pkg::SUM_W'(bot_px);
    assign sum_left  = sem_pkg::SUM_W'(win_reg[0]) + {1'b0, win_reg[1], 1'b0}
                     + sem_pkg::SUM_W'(win_reg[2]);
    assign sum_right = sem_pkg::SUM_W'(top_px) + {1'b0, mid_px, 1'b0}
                     + sem_pkg::SUM_W'(bot_px);

    always_comb
    begin
        s2_word_next.grad_v = $signed({1'b0, sum_bot}) - $signed({1'b0, sum_top});
        s2_word_next.grad_h = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
        s2_word_next.last   = s1_last_reg;
    end

    // Hold gradients for the queue
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_produce_reg)
        begin
            s2_word_reg <= s2_word_next;
        end
    end

    assign push_valid = s2_valid_reg;
    assign push_word  = s2_word_reg;

endmodule

// ----- rtl/sem_queue.sv -----
module sem_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push_valid,
    input  sem_pkg::sem_grad_t           push_word,
    output logic                         pop_valid,
    input  logic                         pop,
    output sem_pkg::sem_grad_t           pop_word,
    output logic [sem_pkg::QCOUNT_W-1:0] count
);

    localparam int PTR_W = (sem_pkg::QUEUE_DEPTH > 1) ? $clog2(sem_pkg::QUEUE_DEPTH) : 1;

    sem_pkg::sem_grad_t          entry_reg [sem_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [sem_pkg::QCOUNT_W-1:0] count_reg, count_next;
    logic                        do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign pop_valid = count_reg != '0;
    assign pop_word  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(sem_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(sem_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push_valid && !do_pop)
        begin
            count_next = count_reg + sem_pkg::QCOUNT_W'(1);
        end
        else if (!push_valid && do_pop)
        begin
            count_next = count_reg - sem_pkg::QCOUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming word
    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- rtl/sem_back.sv -----
module sem_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    output logic                      pop,
    input  sem_pkg::sem_grad_t        pop_word,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [sem_pkg::MAG_W-1:0] magnitude,
    output logic                      last
);

    logic                      out_valid_reg;
    logic [sem_pkg::MAG_W-1:0] magnitude_reg, magnitude_next;
    logic                      last_reg;
    logic [sem_pkg::GRAD_W-1:0] abs_v, abs_h;

    // Take a word whenever the output register is free or being drained
    assign pop = pop_valid && (!out_valid_reg || out_ready);

    // Absolute values and their sum
    assign abs_v = pop_word.grad_v[sem_pkg::GRAD_W-1] ? sem_pkg::GRAD_W'(-pop_word.grad_v)
                                                      : sem_pkg::GRAD_W'(pop_word.grad_v);
    assign abs_h = pop_word.grad_h[sem_pkg::GRAD_W-1] ? sem_pkg::GRAD_W'(-pop_word.grad_h)
                                                      : sem_pkg::GRAD_W'(pop_word.grad_h);
    assign magnitude_next = sem_pkg::MAG_W'(abs_v) + sem_pkg::MAG_W'(abs_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            magnitude_reg <= magnitude_next;
            last_reg      <= pop_word.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign magnitude = magnitude_reg;
    assign last      = last_reg;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int LATENCY_WAIT = 8;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TIMEOUT_NS   = 20_000_000;
    localparam int WIDE_RUN     = 24;

    // Frame slots in the random phase that get special geometry or pressure
    localparam int WIDE_EXACT_FRAME = 2;
    localparam int HOLD_FRAME       = 5;
    localparam int WIDE_CLAMP_FRAME = 7;
    localparam int TALL_FRAME       = 12;

    typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_FLAT} pixel_mix_t;

    // Tracks line stores, window and counters; queues one magnitude per interior pixel
    class edge_scoreboard;
        typedef struct packed {
            logic [sem_pkg::MAG_W-1:0] magnitude;
            logic                      last;
        } edge_result_t;

        logic [sem_pkg::PIXEL_W-1:0] line_mem [2*sem_pkg::MAX_WIDTH];
        logic [sem_pkg::PIXEL_W-1:0] win [6];
        int unsigned                 col;
        int unsigned                 row;
        logic [sem_pkg::CFG_W-1:0]   width_reg;
        logic [sem_pkg::CFG_W-1:0]   height_reg;
        edge_result_t                expected_edges [$];
        int unsigned                 errors;
        int unsigned                 pixels;
        int unsigned                 results;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (win[i]) win[i] = '0;
            col = 0;
            row = 0;
            width_reg = sem_pkg::IMAGE_WIDTH_RST;
            height_reg = sem_pkg::IMAGE_HEIGHT_RST;
            errors = 0;
            pixels = 0;
            results = 0;
        endfunction

        function void write_reg(logic [sem_pkg::REG_IDX_W-1:0] idx,
                                logic [sem_pkg::CFG_W-1:0] value);
            if (idx == sem_pkg::REG_IMAGE_WIDTH)
                width_reg = value;
            else
                height_reg = value;
        endfunction

        function bit at_frame_start();
            return col == 0 && row == 0;
        endfunction

        function int pending();
            return expected_edges.size();
        endfunction

        function void note_pixel(logic [sem_pkg::PIXEL_W-1:0] bot);
            int unsigned w;
            int unsigned h;
            logic [sem_pkg::PIXEL_W-1:0] top;
            logic [sem_pkg::PIXEL_W-1:0] mid;
            bit row_end;
            bit frame_end;
            int lt, lm, lb, ct, cb, rt, rm, rb;
            int gv, gh;
            edge_result_t exp_item;

            w = width_reg;
            if (w < sem_pkg::MIN_DIM) w = sem_pkg::MIN_DIM;
            if (w > sem_pkg::MAX_WIDTH) w = sem_pkg::MAX_WIDTH;
            h = height_reg;
            if (h < sem_pkg::MIN_DIM) h = sem_pkg::MIN_DIM;
            top = '0;
            mid = '0;
            pixels++;

            // shift the column through both line stores
            if (col < sem_pkg::MAX_WIDTH) begin
                top = line_mem[sem_pkg::MAX_WIDTH + col];
                mid = line_mem[col];
                line_mem[sem_pkg::MAX_WIDTH + col] = mid;
                line_mem[col] = bot;
            end

            row_end = col >= w - 1;
            frame_end = row_end && row >= h - 1;

            if (col >= 2 && row >= 2) begin
                lt = win[0];
                lm = win[1];
                lb = win[2];
                ct = win[3];
                cb = win[5];
                rt = top;
                rm = mid;
                rb = bot;
                gv = (lb + 2 * cb + rb) - (lt + 2 * ct + rt);
                gh = (rt + 2 * rm + rb) - (lt + 2 * lm + lb);
                if (gv < 0) gv = -gv;
                if (gh < 0) gh = -gh;
                exp_item.magnitude = sem_pkg::MAG_W'(gv + gh);
                exp_item.last = frame_end;
                expected_edges.push_back(exp_item);
            end

            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = top;
            win[4] = mid;
            win[5] = bot;

            // advance or wrap the raster position
            if (frame_end) begin
                col = 0;
                row = 0;
            end else if (row_end) begin
                col = 0;
                row = (row + 1) & 12'hFFF;
            end else begin
                col = col + 1;
            end
        endfunction

        function void check_result(logic [sem_pkg::MAG_W-1:0] magnitude, logic last);
            edge_result_t exp_item;
            results++;
            if (expected_edges.size() == 0) begin
                $error("unexpected result: magnitude %0d last %0b", magnitude, last);
                errors++;
                return;
            end
            exp_item = expected_edges.pop_front();
            if (magnitude !== exp_item.magnitude) begin
                $error("magnitude: expected %0d, actual %0d", exp_item.magnitude, magnitude);
                errors++;
            end
            if (last !== exp_item.last) begin
                $error("last: expected %0b, actual %0b", exp_item.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [sem_pkg::APB_ADDR_W-1:0] paddr;
    logic [sem_pkg::APB_DATA_W-1:0] pwdata;
    logic [sem_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    sem_pixel_if  pix_if ();
    sem_result_if res_if ();

    edge_scoreboard sb = new();

    bit idle_in;
    bit idle_out;
    bit long_hold;
    int unsigned reg_writes;
    int unsigned resizes;
    int unsigned frames_sent;
    logic [sem_pkg::PIXEL_W-1:0] flat_level;

    sobel_edge_magnitude dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel_stream  (pix_if),
        .result_stream (res_if),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // check every accepted result word
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.magnitude, res_if.last);
    end

    function automatic logic [sem_pkg::PIXEL_W-1:0] gen_pixel(pixel_mix_t mix);
        case (mix)
            PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            PIX_FLAT:    return flat_level ^ sem_pkg::PIXEL_W'($urandom_range(0, 1));
            default:     return sem_pkg::PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [sem_pkg::CFG_W-1:0] pick_width();
        if ($urandom_range(0, 7) == 0)
            return sem_pkg::CFG_W'($urandom_range(0, 2));
        return sem_pkg::CFG_W'($urandom_range(3, 12));
    endfunction

    function automatic logic [sem_pkg::CFG_W-1:0] pick_height();
        if ($urandom_range(0, 7) == 0)
            return sem_pkg::CFG_W'($urandom_range(0, 2));
        return sem_pkg::CFG_W'($urandom_range(3, 8));
    endfunction

    // Offer one pixel word after a random gap; hold valid until taken
    task automatic send_pixel(input logic [sem_pkg::PIXEL_W-1:0] value);
        int gap;
        gap = idle_in ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= value;
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);
        sb.note_pixel(value);
    endtask

    // Send up to count pixels, stopping early when a frame completes
    task automatic send_run(input int count, input pixel_mix_t mix);
        for (int i = 0; i < count; i++) begin
            send_pixel(gen_pixel(mix));
            if (sb.at_frame_start()) begin
                frames_sent++;
                break;
            end
        end
    endtask

    // Drop valid and let the block drain completely
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sem_pkg::REG_IDX_W-1:0] idx,
                             input logic [sem_pkg::CFG_W-1:0] value);
        logic [sem_pkg::APB_DATA_W-1:0] word;
        word = $urandom();
        word[sem_pkg::CFG_W-1:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, value);
        reg_writes++;
        @(posedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int stall;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (long_hold) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            stall = idle_out ? $urandom_range(0, 5) : 0;
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid && !long_hold) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [sem_pkg::PIXEL_W-1:0] peak_frame [9];
        int frame_idx;
        int drain;
        pixel_mix_t mix;

        peak_frame = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd255, 8'd255, 8'd255, 8'd255};
        frame_idx = 0;
        reg_writes = 0;
        resizes = 0;
        frames_sent = 0;
        idle_in = 1'b0;
        idle_out = 1'b0;
        long_hold = 1'b0;
        flat_level = '0;

        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Narrow 3x3 frame from undersized registers, strongest edge in the middle
        write_reg(sem_pkg::REG_IMAGE_WIDTH, 12'd0);
        write_reg(sem_pkg::REG_IMAGE_HEIGHT, 12'd2);
        foreach (peak_frame[i]) send_pixel(peak_frame[i]);
        frames_sent++;
        wait_idle();

        // 5x3 checkerboard of full-scale pixels
        write_reg(sem_pkg::REG_IMAGE_WIDTH, 12'd5);
        write_reg(sem_pkg::REG_IMAGE_HEIGHT, 12'd1);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 5; c++)
                send_pixel(((r + c) % 2 != 0) ? 8'hFF : 8'h00);
        frames_sent++;

        // Random frames, a few of them at the geometric extremes
        while (sb.pixels < RANDOM_ITEMS) begin
            idle_in = $urandom_range(0, 3) != 0;
            idle_out = $urandom_range(0, 3) != 0;
            mix = pixel_mix_t'($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
            flat_level = sem_pkg::PIXEL_W'($urandom_range(0, 255));
            case (frame_idx)
                WIDE_EXACT_FRAME: begin
                    // full-width row cut short, then every column up to 12 filled twice more
                    wait_idle();
                    write_reg(sem_pkg::REG_IMAGE_WIDTH, 12'd2048);
                    write_reg(sem_pkg::REG_IMAGE_HEIGHT,
                              sem_pkg::CFG_W'($urandom_range(0, 3)));
                    send_run(WIDE_RUN, mix);
                    wait_idle();
                    write_reg(sem_pkg::REG_IMAGE_WIDTH, 12'd12);
                    resizes++;
                    send_run(1 << 30, mix);
                end
                HOLD_FRAME: begin
                    // large enough frame to fill the block while results are held off
                    wait_idle();
                    write_reg(sem_pkg::REG_IMAGE_WIDTH, 12'd12);
                    write_reg(sem_pkg::REG_IMAGE_HEIGHT, 12'd8);
                    long_hold = 1'b1;
                    send_run(1 << 30, mix);
                end
                WIDE_CLAMP_FRAME: begin
                    wait_idle();
                    write_reg(sem_pkg::REG_IMAGE_WIDTH, 12'hFFF);
                    write_reg(sem_pkg::REG_IMAGE_HEIGHT, 12'd3);
                    send_run($urandom_range(20, 40), mix);
                    wait_idle();
                    write_reg(sem_pkg::REG_IMAGE_WIDTH, pick_width());
                    resizes++;
                    send_run(1 << 30, mix);
                end
                TALL_FRAME: begin
                    wait_idle();
                    write_reg(sem_pkg::REG_IMAGE_WIDTH, sem_pkg::CFG_W'($urandom_range(0, 3)));
                    write_reg(sem_pkg::REG_IMAGE_HEIGHT, 12'hFFF);
                    send_run(3 * $urandom_range(10, 30), mix);
                    wait_idle();
                    write_reg(sem_pkg::REG_IMAGE_HEIGHT, pick_height());
                    resizes++;
                    send_run(1 << 30, mix);
                end
                default: begin
                    if (frame_idx == 0 || $urandom_range(0, 1) != 0) begin
                        wait_idle();
                        write_reg(sem_pkg::REG_IMAGE_WIDTH, pick_width());
                        write_reg(sem_pkg::REG_IMAGE_HEIGHT, pick_height());
                    end
                    // resize mid-frame only once the first twelve columns hold real pixels
                    if (frame_idx > WIDE_EXACT_FRAME && $urandom_range(0, 4) == 0) begin
                        send_run($urandom_range(1, 40), mix);
                        if (!sb.at_frame_start()) begin
                            wait_idle();
                            if ($urandom_range(0, 2) != 0)
                                write_reg(sem_pkg::REG_IMAGE_WIDTH, pick_width());
                            if ($urandom_range(0, 2) != 0)
                                write_reg(sem_pkg::REG_IMAGE_HEIGHT, pick_height());
                            resizes++;
                            send_run(1 << 30, mix);
                        end
                    end else begin
                        send_run(1 << 30, mix);
                    end
                end
            endcase
            frame_idx++;
        end

        // drain what is still in flight
        pix_if.valid <= 1'b0;
        drain = 0;
        while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (LATENCY_WAIT) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end

        $display("Streamed %0d pixels over %0d frames and checked %0d magnitudes.",
                 sb.pixels, frames_sent, sb.results);
        $display("Widths from clamped 3 to 2048 and 0xFFF, heights to 4095; %0d writes, %0d mid-frame.",
                 reg_writes, resizes);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sem_pkg.sv
rtl/sem_pixel_if.sv
rtl/sem_result_if.sv
rtl/sem_front.sv
rtl/sem_queue.sv
rtl/sem_back.sv
rtl/sobel_edge_magnitude.sv
verif/testbench.sv
